// ===== hdl/b64u_pkg.sv =====
// b64u_pkg: shared types, character constants and alphabet functions of the base64url codec
// no dependencies; used by b64u_front, b64u_queue, b64u_back and base64url_codec_top
`default_nettype none

package b64u_pkg;

  typedef enum logic {
    ModeEncode = 1'b0,
    ModeDecode = 1'b1
  } mode_e;

  typedef struct packed {
    logic [7:0] data_in;
    logic       last_in;
  } in_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       has_data;
    logic       invalid_char;
    logic       last_out;
  } out_t;

  // one queued job: one or two results of a single transaction
  typedef struct packed {
    logic       enc;   // d0/d1 are alphabet indexes
    logic       two;   // second result present
    logic       last;  // final result of the job closes the message
    logic [7:0] d0;    // index or decoded byte
    logic [5:0] d1;    // index of the second character
    logic       has0;  // decode: first result carries a byte
    logic       inv0;  // decode: invalid character
  } job_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } cv_t;

  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7A;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChDash   = 8'h2D;
  localparam logic [7:0] ChUnder  = 8'h5F;

  localparam logic [5:0] IdxLower = 6'd26;
  localparam logic [5:0] IdxDigit = 6'd52;
  localparam logic [5:0] IdxDash  = 6'd62;
  localparam logic [5:0] IdxUnder = 6'd63;

  // 6-bit index to alphabet character
  function automatic logic [7:0] alpha(input logic [5:0] idx);
    logic [7:0] ch;
    if (idx < IdxLower) begin
      ch = ChUpperA + {2'b00, idx};
    end else if (idx < IdxDigit) begin
      ch = ChLowerA + {2'b00, 6'(idx - IdxLower)};
    end else if (idx < IdxDash) begin
      ch = ChZero + {2'b00, 6'(idx - IdxDigit)};
    end else if (idx == IdxDash) begin
      ch = ChDash;
    end else begin
      ch = ChUnder;
    end
    return ch;
  endfunction

  // character to 6-bit value, ok low outside the alphabet
  function automatic cv_t char_value(input logic [7:0] c);
    cv_t r;
    r = '0;
    if (c >= ChUpperA && c <= ChUpperZ) begin
      r.ok  = 1'b1;
      r.val = 6'(c - ChUpperA);
    end else if (c >= ChLowerA && c <= ChLowerZ) begin
      r.ok  = 1'b1;
      r.val = 6'(c - ChLowerA) + IdxLower;
    end else if (c >= ChZero && c <= ChNine) begin
      r.ok  = 1'b1;
      r.val = 6'(c - ChZero) + IdxDigit;
    end else if (c == ChDash) begin
      r.ok  = 1'b1;
      r.val = IdxDash;
    end else if (c == ChUnder) begin
      r.ok  = 1'b1;
      r.val = IdxUnder;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/base64url_codec_top.sv =====
// base64url_codec_top: unpadded base64url codec, front, job queue and back wired together
// depends on b64u_pkg, b64u_front, b64u_queue, b64u_back
//
// Streaming base64url (A-Z a-z 0-9 - _) codec without padding. cfg_wdata_i selects the
// mode (0 encode bytes to characters, 1 decode characters to bytes); a write also drops any
// message in progress and must only happen while the block is idle. In encode mode every
// byte gives one or two characters, and the last byte of a message flushes the leftover bits
// zero-filled into a final character. In decode mode every character gives at most one byte;
// leftover bits at the end are dropped, and a last character that yields no byte gives a
// result with has_data low. A character outside the alphabet gives one result with
// invalid_char and last_out set, and the rest of that message is swallowed up to its last
// item. Rate: the back end delivers one result per cycle while the job queue holds a job and
// out_ready_i lets the output register move on; a decoded character gives at most one result
// and an encoded byte one or two. The front accepts one item per cycle as long as the job
// queue has room; QueueDepth sets how far the front may run ahead of a stalled output. An
// accepted item is written into the job queue, then registered in the back's output register.
`default_nettype none

module base64url_codec_top #(
  parameter int QueueDepth = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  // input transactions
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire b64u_pkg::in_t   in_i,
  // result transactions
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output b64u_pkg::out_t       out_o,
  // mode register write
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_wdata_i
);

  // front to queue
  logic            q_push;
  b64u_pkg::job_t  q_job;
  logic            q_full;
  // queue to back
  b64u_pkg::job_t  q_head;
  logic            q_empty;
  logic            q_pop;

  // front classifies each item and tracks the residue
  b64u_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_i        (in_i),
    .in_ready_o  (in_ready_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .full_i      (q_full),
    .push_o      (q_push),
    .job_o       (q_job)
  );

  // decouples the two sides so each can stall on its own
  b64u_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_job),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back maps indexes to characters and sends results one per cycle unless the output stalls
  b64u_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("job popped from an empty queue");
  a_invalid_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.invalid_char |->
      out_o.last_out && !out_o.has_data && out_o.data_out == 8'h00)
    else $error("invalid character result malformed");
  a_marker_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.has_data |-> out_o.last_out)
    else $error("result without data not closing the message");
`endif

endmodule

`default_nettype wire

// ===== hdl/b64u_front.sv =====
// b64u_front: accepts items, keeps mode, bit residue and error hold, and builds result jobs
// depends on b64u_pkg
`default_nettype none

module b64u_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire b64u_pkg::in_t  in_i,
  output logic                in_ready_o,
  input  wire logic           cfg_we_i,
  input  wire logic           cfg_wdata_i,
  input  wire logic           full_i,
  output logic                push_o,
  output b64u_pkg::job_t      job_o
);

  b64u_pkg::mode_e mode_q, mode_d;
  logic [5:0]      res_q, res_d;
  logic [1:0]      pairs_q, pairs_d;  // residue bit count / 2
  logic            hold_q, hold_d;
  logic            accept;
  logic [7:0]      data;
  logic            last;
  b64u_pkg::cv_t   cv;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign data       = in_i.data_in;
  assign last       = in_i.last_in;
  assign cv         = b64u_pkg::char_value(data);

  always_comb begin
    mode_d  = mode_q;
    res_d   = res_q;
    pairs_d = pairs_q;
    hold_d  = hold_q;
    push_o  = 1'b0;
    job_o   = '0;
    if (cfg_we_i) begin
      mode_d  = b64u_pkg::mode_e'(cfg_wdata_i);
      res_d   = '0;
      pairs_d = '0;
      hold_d  = 1'b0;
    end else if (accept) begin
      if (hold_q) begin
        if (last) begin
          hold_d = 1'b0;
        end
      end else if (mode_q == b64u_pkg::ModeEncode) begin
        push_o   = 1'b1;
        job_o.enc  = 1'b1;
        job_o.last = last;
        unique case (pairs_q)
          2'd0: begin
            job_o.d0  = {2'b00, data[7:2]};
            job_o.two = last;
            job_o.d1  = {data[1:0], 4'b0000};
            res_d     = {4'b0000, data[1:0]};
            pairs_d   = 2'd1;
          end
          2'd1: begin
            job_o.d0  = {2'b00, res_q[1:0], data[7:4]};
            job_o.two = last;
            job_o.d1  = {data[3:0], 2'b00};
            res_d     = {2'b00, data[3:0]};
            pairs_d   = 2'd2;
          end
          2'd2: begin
            job_o.d0  = {2'b00, res_q[3:0], data[7:6]};
            job_o.two = 1'b1;
            job_o.d1  = data[5:0];
            res_d     = '0;
            pairs_d   = 2'd0;
          end
          default: begin
            job_o.d0  = {2'b00, res_q};
            job_o.two = 1'b1;
            job_o.d1  = data[7:2];
            res_d     = {4'b0000, data[1:0]};
            pairs_d   = 2'd1;
          end
        endcase
        if (last) begin
          res_d   = '0;
          pairs_d = '0;
        end
      end else if (!cv.ok) begin
        push_o     = 1'b1;
        job_o.inv0 = 1'b1;
        job_o.last = 1'b1;
        res_d      = '0;
        pairs_d    = '0;
        hold_d     = !last;
      end else begin
        job_o.last = last;
        unique case (pairs_q)
          2'd0: begin
            job_o.has0 = 1'b0;
            res_d      = cv.val;
            pairs_d    = 2'd3;
          end
          2'd1: begin
            job_o.has0 = 1'b1;
            job_o.d0   = {res_q[1:0], cv.val};
            res_d      = '0;
            pairs_d    = 2'd0;
          end
          2'd2: begin
            job_o.has0 = 1'b1;
            job_o.d0   = {res_q[3:0], cv.val[5:2]};
            res_d      = {4'b0000, cv.val[1:0]};
            pairs_d    = 2'd1;
          end
          default: begin
            job_o.has0 = 1'b1;
            job_o.d0   = {res_q, cv.val[5:4]};
            res_d      = {2'b00, cv.val[3:0]};
            pairs_d    = 2'd2;
          end
        endcase
        push_o = job_o.has0 || last;
        if (last) begin
          res_d   = '0;
          pairs_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= b64u_pkg::ModeEncode;
      res_q   <= '0;
      pairs_q <= '0;
      hold_q  <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      res_q   <= res_d;
      pairs_q <= pairs_d;
      hold_q  <= hold_d;
    end
  end

`ifndef ASSERT_OFF
  a_enc_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == b64u_pkg::ModeEncode) |-> !hold_q)
    else $error("error hold set in encode mode");
  a_hold_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q |-> !push_o)
    else $error("job pushed while swallowing");
  a_err_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && job_o.inv0 && !cfg_we_i |=> res_q == '0 && pairs_q == '0)
    else $error("residue not cleared after invalid character");
`endif

endmodule

`default_nettype wire

// ===== hdl/b64u_queue.sv =====
// b64u_queue: small job fifo between the front and the back of the codec
// depends on b64u_pkg
`default_nettype none

module b64u_queue #(
  parameter int Depth = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire b64u_pkg::job_t  job_i,
  input  wire logic            pop_i,
  output b64u_pkg::job_t       head_o,
  output logic                 full_o,
  output logic                 empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  b64u_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/b64u_back.sv =====
// b64u_back: expands queued jobs into result transactions through an output register
// depends on b64u_pkg
`default_nettype none

module b64u_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire b64u_pkg::job_t  head_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output b64u_pkg::out_t       out_o
);

  logic            k_q;  // which result of the head job is next
  logic            out_valid_q;
  b64u_pkg::out_t  out_q, res;
  logic            load;
  logic            final_res;
  logic [5:0]      idx;

  assign load      = !empty_i && (!out_valid_q || out_ready_i);
  assign final_res = (k_q == head_i.two);
  assign pop_o     = load && final_res;
  assign idx       = k_q ? head_i.d1 : head_i.d0[5:0];

  always_comb begin
    res.data_out     = head_i.enc ? b64u_pkg::alpha(idx) : head_i.d0;
    res.has_data     = head_i.enc || head_i.has0;
    res.invalid_char = !head_i.enc && head_i.inv0;
    res.last_out     = head_i.last && final_res;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        k_q         <= !final_res;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire
